### hw/rtl/rwvf_pkg.sv
package rwvf_pkg;

  localparam int DEPTH    = 16;
  localparam int SAMPLE_W = 13;
  localparam int THRESH_W = 9;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(128);
  localparam logic [SAMPLE_W-1:0] EMPTY_SAMPLE = {SAMPLE_W{1'b1}};

  typedef struct packed {
    logic load;
    logic count;
    logic score;
    logic scan;
  } cell_ctrl_t;

endpackage

### hw/rtl/rwvf_ifs.sv
interface rwvf_item_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       cmd;
  logic signed [rwvf_pkg::SAMPLE_W-1:0]       sample_value;

  modport source(output valid, cmd, sample_value, input ready);
  modport sink(input valid, cmd, sample_value, output ready);
endinterface

interface rwvf_vote_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [rwvf_pkg::SAMPLE_W-1:0]       voted_value;
  logic                                       majority_found;

  modport source(output valid, voted_value, majority_found, input ready);
  modport sink(input valid, voted_value, majority_found, output ready);
endinterface

interface rwvf_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [rwvf_pkg::THRESH_W-1:0]              vote_threshold;

  modport source(output valid, vote_threshold, input ready);
  modport sink(input valid, vote_threshold, output ready);
endinterface

### hw/rtl/rwvf_cell.sv
module rwvf_cell #(
  parameter int DEPTH = rwvf_pkg::DEPTH,
  parameter int IDX   = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rwvf_pkg::cell_ctrl_t               ctrl,
  input  logic                               we,
  input  logic [rwvf_pkg::SAMPLE_W-1:0]      wr_value,
  input  logic [$clog2(DEPTH)-1:0]           wp,
  input  logic [rwvf_pkg::SAMPLE_W-1:0]      probe_in,
  input  logic [2*$clog2(DEPTH+1)-1:0]       score_in,
  output logic [rwvf_pkg::SAMPLE_W-1:0]      probe,
  output logic [2*$clog2(DEPTH+1)-1:0]       score
);

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int SUM_W   = PTR_W + 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SCORE_W = 2 * CNT_W;

  logic [rwvf_pkg::SAMPLE_W-1:0] slot;
  logic [CNT_W-1:0]              cnt;
  logic [SUM_W-1:0]              diff;
  logic [SUM_W-1:0]              age;
  logic [CNT_W-1:0]              weight;

  assign diff   = {1'b0, wp} + SUM_W'(DEPTH - 1 - IDX);
  assign age    = (diff >= SUM_W'(DEPTH)) ? diff - SUM_W'(DEPTH) : diff;
  assign weight = CNT_W'(DEPTH) - CNT_W'(age);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= rwvf_pkg::EMPTY_SAMPLE;
    end else if (we) begin
      slot <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      probe <= slot;
      cnt   <= '0;
    end else if (ctrl.count) begin
      probe <= probe_in;
      if (probe == slot) begin
        cnt <= cnt + CNT_W'(1);
      end
    end else if (ctrl.score) begin
      score <= SCORE_W'(cnt) * SCORE_W'(weight);
    end else if (ctrl.scan) begin
      probe <= probe_in;
      score <= score_in;
    end
  end

endmodule

### hw/rtl/rwvf_pick.sv
module rwvf_pick #(
  parameter int SCORE_W = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               take,
  input  logic [SCORE_W-1:0]                 score,
  input  logic [rwvf_pkg::SAMPLE_W-1:0]      value,
  output logic [SCORE_W-1:0]                 best_score,
  output logic [rwvf_pkg::SAMPLE_W-1:0]      best_value
);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best_score <= '0;
      best_value <= '0;
    end else if (take && (score > best_score)) begin
      best_score <= score;
      best_value <= value;
    end
  end

endmodule

### hw/rtl/recency_weighted_vote_filter_unit.sv
// Recency-weighted sliding-window majority vote.
// item (sink): cmd 0 pushes sample_value at the write pointer and advances
// it; cmd 1 fills every slot with sample_value. One word per item.
// vote (source): one word per item, voted_value and majority_found; the
// value is the winner of the weighted vote when its score exceeds the
// threshold, else 0 with majority_found low.
// cfg (sink): vote_threshold, always ready; write only while idle.
// Each item's pass loads the cells, rotates the ring through them to
// count matches, weights the counts, then shifts the scores past the
// comparator; the result is then written to the output register. A new
// item is taken only after the last one's result is in that register.
// Reset fills every slot with -1, clears the write pointer and sets the
// threshold to 128. A stalled result is held in the output register; the
// next item is taken meanwhile, and its result waits until the held word
// has gone.
module recency_weighted_vote_filter_unit #(
  parameter int DEPTH = rwvf_pkg::DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  rwvf_item_if.sink   item,
  rwvf_vote_if.source vote,
  rwvf_cfg_if.sink    cfg
);

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SCORE_W = 2 * CNT_W;
  localparam int CMP_W   = (SCORE_W > rwvf_pkg::THRESH_W) ? SCORE_W : rwvf_pkg::THRESH_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_COUNT,
    S_SCORE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                          state;
  logic [PTR_W-1:0]                step;
  logic [PTR_W-1:0]                wp;
  logic [rwvf_pkg::THRESH_W-1:0]   thr;
  logic                            out_valid;
  logic [rwvf_pkg::SAMPLE_W-1:0]   out_value;
  logic                            out_found;

  logic                            take_item;
  rwvf_pkg::cell_ctrl_t            ctrl;
  logic [rwvf_pkg::SAMPLE_W-1:0]   probe_bus [DEPTH];
  logic [SCORE_W-1:0]              score_bus [DEPTH];
  logic [SCORE_W-1:0]              best_score;
  logic [rwvf_pkg::SAMPLE_W-1:0]   best_value;
  logic                            found;
  logic                            last_step;

  assign item.ready = (state == S_IDLE);
  assign take_item  = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  assign vote.valid          = out_valid;
  assign vote.voted_value    = $signed(out_value);
  assign vote.majority_found = out_found;

  assign ctrl.load  = (state == S_LOAD);
  assign ctrl.count = (state == S_COUNT);
  assign ctrl.score = (state == S_SCORE);
  assign ctrl.scan  = (state == S_SCAN);

  assign last_step = (step == PTR_W'(DEPTH - 1));
  assign found     = CMP_W'(best_score) > CMP_W'(thr);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                          we;
    logic [rwvf_pkg::SAMPLE_W-1:0] probe_in;
    logic [SCORE_W-1:0]            score_in;

    assign we = take_item && (item.cmd || (wp == PTR_W'(i)));

    if (i == DEPTH - 1) begin : g_tail
      assign probe_in = probe_bus[0];
      assign score_in = '0;
    end else begin : g_body
      assign probe_in = probe_bus[i+1];
      assign score_in = score_bus[i+1];
    end

    rwvf_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .we       (we),
      .wr_value (item.sample_value),
      .wp       (wp),
      .probe_in (probe_in),
      .score_in (score_in),
      .probe    (probe_bus[i]),
      .score    (score_bus[i])
    );
  end

  rwvf_pick #(
    .SCORE_W (SCORE_W)
  ) u_pick (
    .clk        (clk),
    .rst        (rst),
    .clear      (ctrl.load),
    .take       (ctrl.scan),
    .score      (score_bus[0]),
    .value      (probe_bus[0]),
    .best_score (best_score),
    .best_value (best_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= rwvf_pkg::THRESH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      thr <= cfg.vote_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      wp        <= '0;
      out_valid <= 1'b0;
      out_value <= '0;
      out_found <= 1'b0;
    end else begin
      if (out_valid && vote.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take_item) begin
            if (!item.cmd) begin
              wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + PTR_W'(1);
            end
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          step  <= '0;
          state <= S_COUNT;
        end
        S_COUNT: begin
          step <= step + PTR_W'(1);
          if (last_step) begin
            state <= S_SCORE;
          end
        end
        S_SCORE: begin
          step  <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          step <= step + PTR_W'(1);
          if (last_step) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || vote.ready) begin
            out_valid <= 1'b1;
            out_value <= found ? best_value : '0;
            out_found <= found;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word raised outside the closing state");

  a_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    (vote.valid && !vote.majority_found) |-> (vote.voted_value == '0))
    else $error("non-zero value without a majority");

  a_wp_stable: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(wp))
    else $error("write pointer moved during a vote pass");

  a_pass_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCORE) |-> $past(state == S_COUNT) && $past(last_step))
    else $error("count pass ended early");
`endif

endmodule

### sim/recency_weighted_vote_filter_unit_tb.sv
module recency_weighted_vote_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = rwvf_pkg::DEPTH;
  localparam int SAMPLE_W = rwvf_pkg::SAMPLE_W;
  localparam int THRESH_W = rwvf_pkg::THRESH_W;
  localparam logic [SAMPLE_W-1:0] EMPTY_SAMPLE = rwvf_pkg::EMPTY_SAMPLE;
  localparam logic [THRESH_W-1:0] THRESH_RESET = rwvf_pkg::THRESH_RESET;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_FILL = 1'b1;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int HOLD_CYCLES = 500;
  localparam int PHASE_ITEMS = 100;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                found;
  } vote_word_t;

  logic clk;
  logic rst;

  rwvf_item_if item_bus();
  rwvf_vote_if vote_bus();
  rwvf_cfg_if  cfg_bus();

  recency_weighted_vote_filter_unit DUT (
    .clk  (clk),
    .rst  (rst),
    .item (item_bus),
    .vote (vote_bus),
    .cfg  (cfg_bus)
  );

  logic [SAMPLE_W-1:0] vote_ring [DEPTH];
  logic [PTR_W-1:0]    ring_head;
  logic [THRESH_W-1:0] vote_limit;
  vote_word_t          expected_votes[$];

  int fail_count = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  bit hold_pending = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic vote_word_t predict_vote(input logic fill, input logic [SAMPLE_W-1:0] smp);
    int best_score;
    int best_slot;
    int match_cnt;
    int age;
    int score;
    vote_word_t res;
    best_score = 0;
    best_slot = 0;
    if (fill == CMD_FILL) begin
      for (int i = 0; i < DEPTH; i++) vote_ring[i] = smp;
    end else begin
      vote_ring[ring_head] = smp;
      ring_head = ring_head + 1'b1;
    end
    for (int i = 0; i < DEPTH; i++) begin
      match_cnt = 0;
      for (int j = 0; j < DEPTH; j++) begin
        if (vote_ring[j] == vote_ring[i]) match_cnt++;
      end
      age = (int'(ring_head) + DEPTH - 1 - i) % DEPTH;
      score = match_cnt * (DEPTH - age);
      if (score > best_score) begin
        best_score = score;
        best_slot = i;
      end
    end
    if (best_score > int'(vote_limit)) begin
      res.value = vote_ring[best_slot];
      res.found = 1'b1;
    end else begin
      res.value = '0;
      res.found = 1'b0;
    end
    return res;
  endfunction

  task automatic send_sample(input logic fill, input logic [SAMPLE_W-1:0] smp);
    item_bus.valid        <= 1'b1;
    item_bus.cmd          <= fill;
    item_bus.sample_value <= smp;
    do @(posedge clk); while (!item_bus.ready);
    expected_votes.push_back(predict_vote(fill, smp));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain_votes();
    item_bus.valid <= 1'b0;
    while (expected_votes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] limit);
    drain_votes();
    cfg_bus.valid          <= 1'b1;
    cfg_bus.vote_threshold <= limit;
    do @(posedge clk); while (!cfg_bus.ready);
    vote_limit = limit;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : vote_check
    vote_word_t want;
    if (!rst && vote_bus.valid && vote_bus.ready) begin
      if (expected_votes.size() == 0) begin
        $error("unexpected vote word: voted_value %0d majority_found %0b",
               vote_bus.voted_value, vote_bus.majority_found);
        fail_count++;
      end else begin
        want = expected_votes.pop_front();
        if (vote_bus.voted_value !== want.value) begin
          $error("voted_value: expected %0d, got %0d", $signed(want.value),
                 vote_bus.voted_value);
          fail_count++;
        end
        if (vote_bus.majority_found !== want.found) begin
          $error("majority_found: expected %0b, got %0b", want.found,
                 vote_bus.majority_found);
          fail_count++;
        end
      end
    end
  end

  initial begin
    vote_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        vote_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        vote_bus.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        vote_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        vote_bus.ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_contents();
    send_sample(CMD_PUSH, 13'h0000);
    send_sample(CMD_PUSH, 13'h0FFF);
    send_sample(CMD_FILL, 13'h1000);
    send_sample(CMD_PUSH, 13'h0AAA);
    send_sample(CMD_PUSH, 13'h1555);
    send_sample(CMD_FILL, EMPTY_SAMPLE);
  endtask

  // two copies of one value, the newer at half weight, against one newest value
  task automatic test_tie_break();
    write_threshold(9'd0);
    for (int k = 1; k <= DEPTH; k++) begin
      if (k == DEPTH) send_sample(CMD_PUSH, 13'h0F0F);
      else if (k == 4 || k == 8) send_sample(CMD_PUSH, 13'h0555);
      else send_sample(CMD_PUSH, SAMPLE_W'(k * 301));
    end
  endtask

  task automatic test_threshold_edges();
    write_threshold(9'd256);
    send_sample(CMD_FILL, 13'h0003);
    send_sample(CMD_PUSH, 13'h0003);
    write_threshold(9'd255);
    send_sample(CMD_FILL, 13'h0003);
    write_threshold(9'd511);
    send_sample(CMD_PUSH, EMPTY_SAMPLE);
  endtask

  task automatic run_phase(input logic [THRESH_W-1:0] limit, input int count);
    logic [SAMPLE_W-1:0] pool [3];
    logic [SAMPLE_W-1:0] smp;
    logic fill;
    write_threshold(limit);
    for (int p = 0; p < 3; p++) begin
      pool[p] = ($urandom_range(0, 3) == 0) ? EMPTY_SAMPLE : SAMPLE_W'($urandom);
    end
    for (int n = 0; n < count; n++) begin
      fill = ($urandom_range(0, 9) == 0) ? CMD_FILL : CMD_PUSH;
      if ($urandom_range(0, 9) < 7) smp = pool[$urandom_range(0, 2)];
      else smp = SAMPLE_W'($urandom);
      send_sample(fill, smp);
    end
  endtask

  task automatic test_random_votes();
    run_phase(9'd0, PHASE_ITEMS);
    run_phase(9'd511, PHASE_ITEMS);
    run_phase(THRESH_W'($urandom_range(1, 255)), PHASE_ITEMS);
    run_phase(THRESH_W'($urandom_range(16, 200)), PHASE_ITEMS);
    run_phase(9'd256, PHASE_ITEMS);
    run_phase(THRESH_W'($urandom_range(0, 256)), PHASE_ITEMS);
  endtask

  task automatic test_output_hold();
    drain_votes();
    idle_on = 1'b0;
    hold_pending = 1'b1;
    for (int n = 0; n < 12; n++) begin
      send_sample(($urandom_range(0, 4) == 0) ? CMD_FILL : CMD_PUSH,
                  SAMPLE_W'($urandom_range(0, 3)));
    end
    drain_votes();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_phase(THRESH_W'($urandom_range(0, 256)), PHASE_ITEMS);
  endtask

  initial begin
    rst                    <= 1'b1;
    item_bus.valid         <= 1'b0;
    item_bus.cmd           <= CMD_PUSH;
    item_bus.sample_value  <= '0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.vote_threshold <= '0;
    for (int i = 0; i < DEPTH; i++) vote_ring[i] = EMPTY_SAMPLE;
    ring_head = '0;
    vote_limit = THRESH_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_contents();
    test_tie_break();
    test_threshold_edges();
    test_random_votes();
    test_output_hold();
    test_steady_stream();
    drain_votes();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
